>>> src/aba_pkg.sv
// ----------------------------------------------------------------------------
// aba_pkg
// shared types, codes and defaults of the arena block allocator
// ----------------------------------------------------------------------------
`default_nettype none
package aba_pkg;

  localparam int DefNumBlocks  = 16;
  localparam int DefAlignBytes = 8;
  localparam int SizeW         = 25;
  localparam int IndexW        = 4;
  localparam int OffsetW       = 24;
  localparam int StatusW       = 2;
  localparam int CfgIdxW       = 1;
  localparam logic [SizeW-1:0] BlockBytesReset    = 25'd2097152;
  localparam logic [SizeW-1:0] KeepThresholdReset = 25'd512;

  localparam logic [CfgIdxW-1:0] RegBlockBytes    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegKeepThreshold = 1'd1;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StOversize = 2'd1;
  localparam logic [StatusW-1:0] StNoBlock  = 2'd2;

  typedef struct packed {
    logic             mode;
    logic [SizeW-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  block_index;
    logic [OffsetW-1:0] byte_offset;
    logic               block_retired;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK_RD, S_WALK_CHK, S_FREE_RD, S_FREE_WR,
    S_DRAIN_RD, S_DRAIN_WR, S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/arena_block_allocator.sv
// ----------------------------------------------------------------------------
// arena_block_allocator
// bump allocator over equal blocks kept on active, full and free lists
// ----------------------------------------------------------------------------
// After reset a clearing pass over every block initializes the block table;
// busy is high meanwhile. Each request holds busy high up to and including
// its done cycle, and the next request is taken at the end of the first
// cycle with busy low. An allocate reads and then checks each active block;
// a fit writes the block and finishes, via S_FREE_WR to push it on the full
// list when it retires. One that fits nowhere takes the free list head, or
// reports no block when the free list is empty. An oversized request goes
// straight to done. A release reads and relinks each block on the active and
// then the full list. The list lengths set the time. The result is shown with
// done for exactly one cycle and the receiver cannot stall it.
`default_nettype none
module arena_block_allocator import aba_pkg::*; #(
  parameter int NumBlocks  = DefNumBlocks,
  parameter int AlignBytes = DefAlignBytes
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire req_t               request,
  output logic                    done,
  output rsp_t                    result,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [SizeW-1:0]   cfg_data
);
  localparam int AW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int LW = $clog2(NumBlocks + 1);
  localparam logic [LW-1:0] Nil = LW'(NumBlocks);
  localparam int PW = SizeW + 13;
  // rounding by reciprocal multiplication, exact for any sum below 2**XW
  localparam int XW = SizeW + 1;
  localparam int AlignLog = $clog2(AlignBytes);
  localparam int RShift = XW + AlignLog;
  localparam longint RecipFull =
    ((longint'(1) << RShift) + longint'(AlignBytes) - 1) / longint'(AlignBytes);
  localparam logic [XW:0] Recip = (XW+1)'(RecipFull);

  logic [SizeW-1:0] block_bytes, keep_threshold;
  state_t state, state_next;
  logic [LW-1:0] active_head, full_head, free_head, cur, prev, drain_cur;
  logic [LW-1:0] steps;
  logic drain_full;
  logic [SizeW:0] padded;
  rsp_t res;

  logic [AW-1:0] rd_addr;
  logic [SizeW-1:0] rd_used;
  logic [LW-1:0] rd_link;
  logic wu_en, wl_en;
  logic [AW-1:0] wu_addr, wl_addr;
  logic [SizeW-1:0] wu_data;
  logic [LW-1:0] wl_data;

  aba_store #(.NumBlocks(NumBlocks), .AW(AW), .LW(LW)) u_store (
    .clk, .rd_addr, .rd_used, .rd_link,
    .wr_used_en(wu_en), .wr_used_addr(wu_addr), .wr_used(wu_data),
    .wr_link_en(wl_en), .wr_link_addr(wl_addr), .wr_link(wl_data)
  );

  // rounding to the alignment
  logic [XW-1:0] sum_w, quo_w;
  logic [2*XW:0] prod_w;
  logic [PW-1:0] pad_w;
  always_comb begin
    sum_w = XW'(request.request_bytes) + XW'(AlignBytes - 1);
    prod_w = (2*XW+1)'(sum_w) * (2*XW+1)'(Recip);
    quo_w = XW'(prod_w >> RShift);
    pad_w = PW'(quo_w) * PW'(AlignBytes);
  end

  // room of the block just read, and of it after carving
  logic [SizeW-1:0] room, room_after, new_used, free_room;
  logic fits;
  always_comb begin
    room = (rd_used >= block_bytes) ? '0 : block_bytes - rd_used;
    fits = {1'b0, room} >= padded;
    new_used = rd_used + padded[SizeW-1:0];
    room_after = (new_used >= block_bytes) ? '0 : block_bytes - new_used;
    free_room = ({1'b0, padded[SizeW-1:0]} >= {1'b0, block_bytes}) ? '0
                : block_bytes - padded[SizeW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BlockBytesReset;
      keep_threshold <= KeepThresholdReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegBlockBytes:    block_bytes <= cfg_data;
        RegKeepThreshold: keep_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [LW-1:0] active_head_n, full_head_n, free_head_n, cur_n, prev_n;
  logic [LW-1:0] drain_cur_n, steps_n;
  logic drain_full_n;
  logic [SizeW:0] padded_n;
  rsp_t res_n;

  always_comb begin
    state_next = state;
    active_head_n = active_head; full_head_n = full_head; free_head_n = free_head;
    cur_n = cur; prev_n = prev; drain_cur_n = drain_cur; steps_n = steps;
    drain_full_n = drain_full; padded_n = padded; res_n = res;
    rd_addr = cur[AW-1:0];
    wu_en = 1'b0; wu_addr = cur[AW-1:0]; wu_data = '0;
    wl_en = 1'b0; wl_addr = cur[AW-1:0]; wl_data = Nil;
    case (state)
      S_INIT: begin
        // clearing pass: used zero, free chain in index order
        wu_en = 1'b1;
        wl_en = 1'b1;
        wl_data = (cur == '0) ? Nil : cur + 1'b1;
        cur_n = cur + 1'b1;
        if (cur == Nil - 1'b1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          res_n = '0;
          steps_n = '0;
          prev_n = Nil;
          if (request.mode) begin
            drain_cur_n = active_head;
            drain_full_n = 1'b0;
            active_head_n = Nil;
            full_head_n = Nil;
            state_next = S_DRAIN_RD;
          end else if (pad_w > PW'(block_bytes)) begin
            res_n.status = StOversize;
            state_next = S_DONE;
          end else begin
            padded_n = pad_w[SizeW:0];
            cur_n = active_head;
            state_next = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        if (cur == Nil || steps == Nil) begin
          if (free_head == Nil) begin
            res_n.status = StNoBlock;
            state_next = S_DONE;
          end else begin
            rd_addr = free_head[AW-1:0];
            cur_n = free_head;
            state_next = S_FREE_RD;
          end
        end else state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (fits) begin
          wu_en = 1'b1;
          wu_data = new_used;
          res_n.block_index = IndexW'(cur);
          res_n.byte_offset = rd_used[OffsetW-1:0];
          if (room_after < keep_threshold) begin
            res_n.block_retired = 1'b1;
            if (prev == Nil) active_head_n = rd_link;
            else begin
              wl_en = 1'b1; wl_addr = prev[AW-1:0]; wl_data = rd_link;
            end
            state_next = S_FREE_WR;
          end else state_next = S_DONE;
        end else begin
          prev_n = cur;
          cur_n = rd_link;
          steps_n = steps + 1'b1;
          state_next = S_WALK_RD;
        end
      end
      S_FREE_RD: begin
        // link of the free head is in rd_link
        free_head_n = rd_link;
        wu_en = 1'b1;
        wu_data = padded[SizeW-1:0];
        wl_en = 1'b1;
        res_n.block_index = IndexW'(cur);
        if (free_room < keep_threshold) begin
          wl_data = full_head; full_head_n = cur; res_n.block_retired = 1'b1;
        end else begin
          wl_data = active_head; active_head_n = cur;
        end
        state_next = S_DONE;
      end
      S_FREE_WR: begin
        // push the retired active block on the full list
        wl_en = 1'b1; wl_data = full_head; full_head_n = cur;
        state_next = S_DONE;
      end
      S_DRAIN_RD: begin
        rd_addr = drain_cur[AW-1:0];
        if (drain_cur == Nil || steps == Nil) begin
          if (drain_full) state_next = S_DONE;
          else begin
            drain_full_n = 1'b1; drain_cur_n = full_head; steps_n = '0;
          end
        end else state_next = S_DRAIN_WR;
      end
      S_DRAIN_WR: begin
        wl_en = 1'b1; wl_addr = drain_cur[AW-1:0]; wl_data = free_head;
        free_head_n = drain_cur;
        drain_cur_n = rd_link;
        steps_n = steps + 1'b1;
        state_next = S_DRAIN_RD;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // full_head is cleared at release start, so remember the old list
  logic [LW-1:0] full_save;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cur <= '0;
      active_head <= '0;
      full_head <= Nil;
      free_head <= (NumBlocks > 1) ? LW'(1) : Nil;
    end else begin
      state <= state_next;
      cur <= cur_n;
      active_head <= active_head_n;
      full_head <= full_head_n;
      free_head <= free_head_n;
    end
    if (state == S_IDLE && start && request.mode) full_save <= full_head;
    prev <= prev_n;
    drain_cur <= (state == S_DRAIN_RD && state_next == S_DRAIN_RD) ? full_save
                 : drain_cur_n;
    steps <= steps_n;
    drain_full <= drain_full_n;
    padded <= padded_n;
    res <= res_n;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign result = res;

`ifndef ASSERT_OFF
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_nok_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != StOk) |-> (result.block_index == '0 &&
    !result.block_retired)) else $error("fields set on error");
`endif
endmodule
`default_nettype wire

>>> src/aba_store.sv
// ----------------------------------------------------------------------------
// aba_store
// block table: used bytes and next link per block, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module aba_store import aba_pkg::*; #(
  parameter int NumBlocks = DefNumBlocks,
  parameter int AW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1,
  parameter int LW = $clog2(NumBlocks + 1)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    rd_addr,
  output logic [SizeW-1:0]      rd_used,
  output logic [LW-1:0]         rd_link,
  input  wire logic             wr_used_en,
  input  wire logic [AW-1:0]    wr_used_addr,
  input  wire logic [SizeW-1:0] wr_used,
  input  wire logic             wr_link_en,
  input  wire logic [AW-1:0]    wr_link_addr,
  input  wire logic [LW-1:0]    wr_link
);
  logic [SizeW-1:0] used_mem [NumBlocks];
  logic [LW-1:0]    link_mem [NumBlocks];

  always_ff @(posedge clk) begin
    if (wr_used_en) used_mem[wr_used_addr] <= wr_used;
    if (wr_link_en) link_mem[wr_link_addr] <= wr_link;
    rd_used <= used_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the arena block allocator: directed and random
// allocate/release requests under several block sizes and thresholds, each
// result checked against a behavioral model of the three block lists
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import aba_pkg::*;

  localparam int NB = DefNumBlocks;
  localparam int AL = DefAlignBytes;
  localparam int NIL = NB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = RegBlockBytes;
  logic [SizeW-1:0] cfg_data = '0;

  arena_block_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // allocator model state
  logic [SizeW-1:0] blk_size, keep_min;
  logic [SizeW-1:0] used[NB];
  int link[NB];
  int act_head, full_head, free_head;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  bit hold = 1'b0;
  bit drain_pause = 1'b0;
  int burst_left = 0, gap_left = 0;

  function automatic logic [SizeW-1:0] room(int b);
    return (used[b] >= blk_size) ? '0 : blk_size - used[b];
  endfunction

  function automatic void model_reset();
    blk_size = BlockBytesReset;
    keep_min = KeepThresholdReset;
    for (int i = 0; i < NB; i++) begin
      used[i] = '0;
      link[i] = i + 1;
    end
    link[0] = NIL;
    act_head = 0;
    full_head = NIL;
    free_head = (NB > 1) ? 1 : NIL;
  endfunction

  function automatic void push_free(int head);
    int cur, nxt, n;
    cur = head;
    n = 0;
    while (cur < NB && n < NB) begin
      nxt = link[cur];
      link[cur] = free_head;
      free_head = cur;
      cur = nxt;
      n++;
    end
  endfunction

  function automatic rsp_t allocate(req_t r);
    rsp_t o;
    longint padded;
    int prev, cur, n, a, f;
    logic [SizeW-1:0] off;
    bit ret;
    o = '0;
    o.status = StOk;
    if (r.mode) begin
      a = act_head;
      f = full_head;
      act_head = NIL;
      full_head = NIL;
      push_free(a);
      push_free(f);
      return o;
    end
    padded = ((longint'(r.request_bytes) + AL - 1) / AL) * AL;
    if (padded > blk_size) begin
      o.status = StOversize;
      return o;
    end
    prev = NIL;
    cur = act_head;
    n = 0;
    while (cur < NB && n < NB) begin
      if (longint'(room(cur)) >= padded) begin
        off = used[cur];
        used[cur] = SizeW'(longint'(off) + padded);
        ret = room(cur) < keep_min;
        if (ret) begin
          if (prev < NB) link[prev] = link[cur];
          else act_head = link[cur];
          link[cur] = full_head;
          full_head = cur;
        end
        o.block_index = IndexW'(cur);
        o.byte_offset = OffsetW'(off);
        o.block_retired = ret;
        return o;
      end
      prev = cur;
      cur = link[cur];
      n++;
    end
    if (free_head >= NB) begin
      o.status = StNoBlock;
      return o;
    end
    cur = free_head;
    free_head = link[cur];
    used[cur] = SizeW'(padded);
    o.block_index = IndexW'(cur);
    if (room(cur) < keep_min) begin
      link[cur] = full_head;
      full_head = cur;
      o.block_retired = 1'b1;
    end else begin
      link[cur] = act_head;
      act_head = cur;
    end
    return o;
  endfunction

  // driver: bursts and gaps, requests predicted when accepted
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_rsps.push_back(allocate(request));
      if (gap_left == 0 && burst_left > 0 && pending_reqs.size() > 0 && !hold) begin
        request <= pending_reqs.pop_front();
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0 && !hold
                   && !(drain_pause && expected_rsps.size() > 0)) begin
        request <= pending_reqs.pop_front();
        start <= 1'b1;
        if (burst_left == 0) burst_left <= $urandom_range(1, 12);
        else burst_left <= burst_left - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (result.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, result.status);
        if (result.block_index !== exp_r.block_index)
          $display("%0t: block_index expected %0d actual %0d", $time,
                   exp_r.block_index, result.block_index);
        if (result.byte_offset !== exp_r.byte_offset)
          $display("%0t: byte_offset expected %0d actual %0d", $time,
                   exp_r.byte_offset, result.byte_offset);
        if (result.block_retired !== exp_r.block_retired)
          $display("%0t: block_retired expected %0d actual %0d", $time,
                   exp_r.block_retired, result.block_retired);
        if (result !== exp_r) errors++;
      end
    end
  end

  function automatic req_t mk(bit m, logic [SizeW-1:0] n);
    req_t r;
    r.mode = m;
    r.request_bytes = n;
    return r;
  endfunction

  task automatic settle();
    while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == RegBlockBytes) blk_size = val;
    else keep_min = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random size mostly near the block size scale, sometimes any 25-bit value
  function automatic logic [SizeW-1:0] rnd_size(logic [SizeW-1:0] bs);
    case ($urandom_range(0, 5))
      0: return SizeW'($urandom);
      1: return SizeW'($urandom_range(0, 16));
      2: return bs - SizeW'($urandom_range(0, 8));
      default: return SizeW'($urandom_range(0, (bs > 4) ? bs / 4 : bs));
    endcase
  endfunction

  task automatic run_phase(logic [SizeW-1:0] bs, logic [SizeW-1:0] km, int n);
    req_t r;
    write_reg(RegBlockBytes, bs);
    write_reg(RegKeepThreshold, km);
    for (int i = 0; i < n; i++) begin
      r = mk($urandom_range(0, 24) == 0, rnd_size(bs));
      pending_reqs.push_back(r);
    end
    settle();
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    hold = 1'b1;
    // directed: reset config, extremes, zero size, oversize, exhaustion, release
    pending_reqs.push_back(mk(1'b0, 25'd0));
    pending_reqs.push_back(mk(1'b0, 25'd1));
    pending_reqs.push_back(mk(1'b0, 25'd9));
    pending_reqs.push_back(mk(1'b0, 25'd2097152));
    pending_reqs.push_back(mk(1'b0, 25'd2097153));
    pending_reqs.push_back(mk(1'b0, 25'h1FFFFFF));
    pending_reqs.push_back(mk(1'b0, 25'd2096640));
    for (int i = 0; i < 15; i++) pending_reqs.push_back(mk(1'b0, 25'd2097152));
    pending_reqs.push_back(mk(1'b1, 25'h1FFFFFF));
    pending_reqs.push_back(mk(1'b0, 25'd16777216));
    hold = 1'b0;
    settle();
    // tiny blocks, zero threshold, then shrink below used room
    run_phase(25'd64, 25'd0, 120);
    write_reg(RegBlockBytes, 25'd8);
    pending_reqs.push_back(mk(1'b0, 25'd0));
    pending_reqs.push_back(mk(1'b0, 25'd8));
    settle();
    run_phase(25'd1, 25'd1, 60);
    // pause until everything has drained, then continue
    drain_pause = 1'b1;
    run_phase(25'd256, 25'd32, 150);
    drain_pause = 1'b0;
    run_phase(25'd16777216, 25'd16777216, 80);
    run_phase(25'h1FFFFFF, 25'h1FFFFFF, 60);
    run_phase(25'd4096, 25'd100, 250);
    run_phase(25'd1000, 25'd0, 200);
    run_phase(BlockBytesReset, KeepThresholdReset, 100);
    if (errors == 0) begin
      $display("arena_block_allocator test passed");
    end else begin
      $display("arena_block_allocator test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("arena_block_allocator test failed");
    $finish;
  end

endmodule
